@@ rtl/qbcp_pkg.sv @@
//------------------------------------------------------------------------------
// qbcp_pkg: shared types, constants and arithmetic for the closest-point search
// Holds the word types, the coefficient type and the curve evaluation helpers.
//------------------------------------------------------------------------------
package qbcp_pkg;

    localparam int ITERATIONS  = 10;
    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;
    localparam int CFG_IDX_BITS = 3;
    // coefficient a spans four coordinates, b two
    localparam int COEF_BITS   = COORD_BITS + 3;
    // a*tt and b*t products and their sum
    localparam int PROD_BITS   = COEF_BITS + T_BITS + 1;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DIST_BITS   = 2 * DIFF_BITS + 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HANDLE_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HANDLE_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FINISH_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FINISH_Y = 3'd5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [T_BITS-1:0]     t_param;
    typedef logic signed [COEF_BITS-1:0]  t_coef;
    typedef logic        [DIST_BITS-1:0]  t_dist;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
    } t_in_word;

    typedef struct packed {
        t_coord near_x;
        t_coord near_y;
        t_param near_t;
    } t_out_word;

    // Per-axis curve coefficients.
    typedef struct packed {
        t_coef  a;
        t_coef  b;
        t_coord c;
    } t_axis;

    // What moves from cell to cell.
    typedef struct packed {
        logic   valid;
        t_coord qx;
        t_coord qy;
        t_param t0;
        t_param t1;
    } t_cell_bus;

    localparam t_param T_ONE = t_param'(1) << T_FRAC_BITS;

    function automatic t_coord sat_coord(input logic signed [PROD_BITS:0] v);
        logic signed [PROD_BITS:0] cmax;
        logic signed [PROD_BITS:0] cmin;
        cmax = (PROD_BITS+1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        cmin = -cmax - (PROD_BITS+1)'(1);
        if (v > cmax) return t_coord'(cmax);
        if (v < cmin) return t_coord'(cmin);
        return t_coord'(v);
    endfunction

    // Square of a parameter, (t*t) >> F, rounded down.
    function automatic t_param square_t(input t_param t);
        logic [2*T_BITS-1:0] sq;
        sq = t * t;
        return sq[T_FRAC_BITS +: T_BITS];
    endfunction

    // c + floor((a*tt + b*t) / 2^F), saturated; tt is the square from square_t.
    function automatic t_coord curve_pt(input t_axis ax, input t_param t,
                                        input t_param tt);
        logic signed [T_BITS:0]      tts;
        logic signed [T_BITS:0]      ts;
        logic signed [PROD_BITS-1:0] acc;
        logic signed [PROD_BITS:0]   sum;
        tts = $signed({1'b0, tt});
        ts  = $signed({1'b0, t});
        acc = PROD_BITS'(ax.a * tts) + PROD_BITS'(ax.b * ts);
        sum = (PROD_BITS+1)'(ax.c) + (PROD_BITS+1)'(acc >>> T_FRAC_BITS);
        return sat_coord(sum);
    endfunction

    function automatic t_dist sq_dist(input t_coord x, input t_coord y,
                                      input t_coord qx, input t_coord qy);
        logic signed [DIFF_BITS-1:0] dx;
        logic signed [DIFF_BITS-1:0] dy;
        logic [2*DIFF_BITS-1:0]      sx;
        logic [2*DIFF_BITS-1:0]      sy;
        dx = DIFF_BITS'(x) - DIFF_BITS'(qx);
        dy = DIFF_BITS'(y) - DIFF_BITS'(qy);
        sx = $unsigned((2*DIFF_BITS)'(dx * dx));
        sy = $unsigned((2*DIFF_BITS)'(dy * dy));
        return DIST_BITS'(sx) + DIST_BITS'(sy);
    endfunction

endpackage

@@ rtl/qbcp_cell.sv @@
//------------------------------------------------------------------------------
// qbcp_cell: one refinement round
// Samples five parameters, keeps the nearest (earliest on ties) and narrows.
//------------------------------------------------------------------------------
module qbcp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_stall,
    input  qbcp_pkg::t_axis     i_axis_x,
    input  qbcp_pkg::t_axis     i_axis_y,
    input  qbcp_pkg::t_cell_bus i_bus,
    output qbcp_pkg::t_cell_bus o_bus
);

    // First step: sample parameters and their squares.
    qbcp_pkg::t_param    tm;
    qbcp_pkg::t_param    n_ts [5];
    qbcp_pkg::t_param    n_tt [5];
    logic                r_a_valid;
    qbcp_pkg::t_coord    r_a_qx;
    qbcp_pkg::t_coord    r_a_qy;
    qbcp_pkg::t_param    r_a_ts [5];
    qbcp_pkg::t_param    r_a_tt [5];

    // Second step: curve points.
    qbcp_pkg::t_coord    n_px [5];
    qbcp_pkg::t_coord    n_py [5];
    logic                r_b_valid;
    qbcp_pkg::t_coord    r_b_qx;
    qbcp_pkg::t_coord    r_b_qy;
    qbcp_pkg::t_param    r_b_ts [5];
    qbcp_pkg::t_coord    r_b_px [5];
    qbcp_pkg::t_coord    r_b_py [5];

    // Third step: distances, choice and the narrowed interval.
    qbcp_pkg::t_dist     sq_d [5];
    logic [2:0]          best;
    qbcp_pkg::t_cell_bus r_bus;
    qbcp_pkg::t_cell_bus n_bus;

    always_comb begin
        tm      = qbcp_pkg::t_param'(({1'b0, i_bus.t0} + {1'b0, i_bus.t1}) >> 1);
        n_ts[0] = i_bus.t0;
        n_ts[1] = qbcp_pkg::t_param'(({1'b0, i_bus.t0} + {1'b0, tm}) >> 1);
        n_ts[2] = tm;
        n_ts[3] = qbcp_pkg::t_param'(({1'b0, tm} + {1'b0, i_bus.t1}) >> 1);
        n_ts[4] = i_bus.t1;
        for (int k = 0; k < 5; k++) begin
            n_tt[k] = qbcp_pkg::square_t(n_ts[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!i_stall) begin
            r_a_valid <= i_bus.valid;
            r_a_qx    <= i_bus.qx;
            r_a_qy    <= i_bus.qy;
            r_a_ts    <= n_ts;
            r_a_tt    <= n_tt;
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_px[k] = qbcp_pkg::curve_pt(i_axis_x, r_a_ts[k], r_a_tt[k]);
            n_py[k] = qbcp_pkg::curve_pt(i_axis_y, r_a_ts[k], r_a_tt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!i_stall) begin
            r_b_valid <= r_a_valid;
            r_b_qx    <= r_a_qx;
            r_b_qy    <= r_a_qy;
            r_b_ts    <= r_a_ts;
            r_b_px    <= n_px;
            r_b_py    <= n_py;
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            sq_d[k] = qbcp_pkg::sq_dist(r_b_px[k], r_b_py[k], r_b_qx, r_b_qy);
        end
        best = 3'd0;
        if (sq_d[1] < sq_d[best]) best = 3'd1;
        if (sq_d[2] < sq_d[best]) best = 3'd2;
        if (sq_d[3] < sq_d[best]) best = 3'd3;
        if (sq_d[4] < sq_d[best]) best = 3'd4;
        n_bus.valid = r_b_valid;
        n_bus.qx    = r_b_qx;
        n_bus.qy    = r_b_qy;
        case (best)
            3'd0:    begin n_bus.t0 = r_b_ts[0]; n_bus.t1 = r_b_ts[1]; end
            3'd1:    begin n_bus.t0 = r_b_ts[0]; n_bus.t1 = r_b_ts[2]; end
            3'd2:    begin n_bus.t0 = r_b_ts[1]; n_bus.t1 = r_b_ts[3]; end
            3'd3:    begin n_bus.t0 = r_b_ts[2]; n_bus.t1 = r_b_ts[4]; end
            default: begin n_bus.t0 = r_b_ts[3]; n_bus.t1 = r_b_ts[4]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (!i_stall) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bus.valid |-> r_bus.t0 <= r_bus.t1)
        else $error("interval inverted");
    a_interval_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bus.valid |-> r_bus.t1 <= qbcp_pkg::T_ONE)
        else $error("interval beyond one");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_stall) && $past(i_rst_n) && r_bus.valid |-> $stable(r_bus))
        else $error("cell moved while stalled");

endmodule

@@ rtl/qbcp_finish.sv @@
//------------------------------------------------------------------------------
// qbcp_finish: output stage
// Evaluates the curve at the final midpoint and holds the result word.
//------------------------------------------------------------------------------
module qbcp_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_stall,
    input  qbcp_pkg::t_axis     i_axis_x,
    input  qbcp_pkg::t_axis     i_axis_y,
    input  qbcp_pkg::t_cell_bus i_bus,
    output logic                o_valid,
    output qbcp_pkg::t_out_word o_word
);

    qbcp_pkg::t_param    tm;
    qbcp_pkg::t_param    n_tt;
    logic                r_a_valid;
    qbcp_pkg::t_param    r_a_t;
    qbcp_pkg::t_param    r_a_tt;
    qbcp_pkg::t_out_word n_word;
    qbcp_pkg::t_out_word r_word;
    logic                r_valid;

    // First step: midpoint and its square.
    always_comb begin
        tm   = qbcp_pkg::t_param'(({1'b0, i_bus.t0} + {1'b0, i_bus.t1}) >> 1);
        n_tt = qbcp_pkg::square_t(tm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!i_stall) begin
            r_a_valid <= i_bus.valid;
            r_a_t     <= tm;
            r_a_tt    <= n_tt;
        end
    end

    // Second step: the curve point itself.
    always_comb begin
        n_word.near_x = qbcp_pkg::curve_pt(i_axis_x, r_a_t, r_a_tt);
        n_word.near_y = qbcp_pkg::curve_pt(i_axis_y, r_a_t, r_a_tt);
        n_word.near_t = r_a_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_stall) begin
            r_valid <= r_a_valid;
            r_word  <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_word.near_t <= qbcp_pkg::T_ONE)
        else $error("result parameter beyond one");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_stall) |-> r_valid == $past(r_a_valid))
        else $error("result valid lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_stall) |-> $stable(r_valid))
        else $error("result changed while stalled");

endmodule

@@ rtl/quad_bezier_closest_point_top.sv @@
//------------------------------------------------------------------------------
// quad_bezier_closest_point_top: closest point on a quadratic Bezier curve
// A row of refinement cells narrows the parameter interval for each query.
//------------------------------------------------------------------------------
//  channel | handshake                      | word
//  input   | i_in_valid / o_in_stall        | query_x, query_y
//  output  | o_out_valid / i_out_stall      | near_x, near_y, near_t
//  config  | i_cfg_valid / o_cfg_ready      | register index, data
//
// One word enters per cycle while the output does not stall. Each of the ITERATIONS
// cells works a round in registered steps (sample parameters and squares,
// curve points, distances and the choice), and the output stage adds its own
// registered steps (midpoint and its square, curve point); the throughput is set
// by the cell row, one word per cycle while the output does not stall.
// Reset clears the valid flags of the row and the control points to zero.
// A stall at the output freezes the whole row; the input is stalled with it,
// so no word is dropped. Configuration writes are always accepted.
//------------------------------------------------------------------------------
module quad_bezier_closest_point_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  qbcp_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output qbcp_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qbcp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [qbcp_pkg::COORD_BITS-1:0]      i_cfg_data
);

    // Control point registers.
    qbcp_pkg::t_coord r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0x <= '0; r_p0y <= '0;
            r_p1x <= '0; r_p1y <= '0;
            r_p2x <= '0; r_p2y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qbcp_pkg::REG_START_X:  r_p0x <= i_cfg_data;
                qbcp_pkg::REG_START_Y:  r_p0y <= i_cfg_data;
                qbcp_pkg::REG_HANDLE_X: r_p1x <= i_cfg_data;
                qbcp_pkg::REG_HANDLE_Y: r_p1y <= i_cfg_data;
                qbcp_pkg::REG_FINISH_X: r_p2x <= i_cfg_data;
                qbcp_pkg::REG_FINISH_Y: r_p2y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Coefficients a = p0 - 2 p1 + p2, b = 2 (p1 - p0), c = p0, registered.
    qbcp_pkg::t_axis r_axis_x, r_axis_y;

    always_ff @(posedge i_clk) begin
        r_axis_x.a <= qbcp_pkg::t_coef'(r_p0x) - (qbcp_pkg::t_coef'(r_p1x) <<< 1)
                      + qbcp_pkg::t_coef'(r_p2x);
        r_axis_x.b <= (qbcp_pkg::t_coef'(r_p1x) - qbcp_pkg::t_coef'(r_p0x)) <<< 1;
        r_axis_x.c <= r_p0x;
        r_axis_y.a <= qbcp_pkg::t_coef'(r_p0y) - (qbcp_pkg::t_coef'(r_p1y) <<< 1)
                      + qbcp_pkg::t_coef'(r_p2y);
        r_axis_y.b <= (qbcp_pkg::t_coef'(r_p1y) - qbcp_pkg::t_coef'(r_p0y)) <<< 1;
        r_axis_y.c <= r_p0y;
    end

    // The whole row advances together unless the output side stalls.
    logic                stall;
    qbcp_pkg::t_cell_bus bus [qbcp_pkg::ITERATIONS + 1];

    assign stall      = i_out_stall;
    assign o_in_stall = stall;

    assign bus[0] = '{valid: i_in_valid,
                      qx:    i_in_word.query_x,
                      qy:    i_in_word.query_y,
                      t0:    '0,
                      t1:    qbcp_pkg::T_ONE};

    for (genvar g = 0; g < qbcp_pkg::ITERATIONS; g++) begin : g_cell
        qbcp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_stall  (stall),
            .i_axis_x (r_axis_x),
            .i_axis_y (r_axis_y),
            .i_bus    (bus[g]),
            .o_bus    (bus[g+1])
        );
    end

    qbcp_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stall  (stall),
        .i_axis_x (r_axis_x),
        .i_axis_y (r_axis_y),
        .i_bus    (bus[qbcp_pkg::ITERATIONS]),
        .o_valid  (o_out_valid),
        .o_word   (o_out_word)
    );

    a_stall_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == i_out_stall)
        else $error("input and output stall differ");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid && i_out_stall) |-> o_out_valid)
        else $error("stalled result dropped");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

@@ verif/quad_bezier_closest_point_top_tb.sv @@
//------------------------------------------------------------------------------
// quad_bezier_closest_point_top_tb: self-checking bench for the curve search
// Loads several sets of control points, sends query words through the input
// channel and compares every result word with an in-bench fixed-point model.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module quad_bezier_closest_point_top_tb;

    import qbcp_pkg::*;

    localparam int  CLK_HALF       = 2;
    localparam int  RESET_CYCLES   = 9;
    localparam int  ITEMS_PER_SET  = 190;
    localparam int  DRAIN_CYCLES   = ITERATIONS + 6;
    localparam int  HOLD_CYCLES    = 80;
    localparam int  HOLD_AT_COUNT  = 200;
    localparam longint COORD_MAX   = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN   = -COORD_MAX - 1;

    // Idle patterns for the two channels, in the order they are used.
    typedef enum logic [1:0] {
        IDLE_SENDER_LIGHT,
        IDLE_RECEIVER_LIGHT,
        IDLE_NONE
    } t_idle_mode;

    // Expected results and the model of the search that produces them.
    class closest_point_board;
        t_coord    ctrl[6];
        t_out_word pending[$];
        int        mismatches;

        function new();
            foreach (ctrl[i]) ctrl[i] = '0;
            mismatches = 0;
        endfunction

        // Mirrors a register write; indexes past the last point are dropped.
        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, t_coord data);
            if (idx <= REG_FINISH_Y) ctrl[idx] = data;
        endfunction

        function longint point_on_curve(longint a, longint b, longint c, longint t);
            longint tt;
            longint v;
            tt = (t * t) >> T_FRAC_BITS;
            v  = c + ((a * tt + b * t) >>> T_FRAC_BITS);
            if (v > COORD_MAX) v = COORD_MAX;
            if (v < COORD_MIN) v = COORD_MIN;
            return v;
        endfunction

        function t_out_word search_nearest(t_in_word q);
            longint    ax, bx, cx, ay, by, cy, qx, qy;
            longint    t0, t1, tm, dx, dy, sq_len, best_len;
            longint    samples[5];
            int        best;
            t_out_word r;
            cx = ctrl[REG_START_X];
            cy = ctrl[REG_START_Y];
            ax = cx - 2 * longint'(ctrl[REG_HANDLE_X]) + longint'(ctrl[REG_FINISH_X]);
            ay = cy - 2 * longint'(ctrl[REG_HANDLE_Y]) + longint'(ctrl[REG_FINISH_Y]);
            bx = 2 * (longint'(ctrl[REG_HANDLE_X]) - cx);
            by = 2 * (longint'(ctrl[REG_HANDLE_Y]) - cy);
            qx = q.query_x;
            qy = q.query_y;
            t0 = 0;
            t1 = longint'(1) << T_FRAC_BITS;
            tm = t1 >> 1;
            for (int it = 0; it < ITERATIONS; it++) begin
                samples[0] = t0;
                samples[1] = (t0 + tm) >> 1;
                samples[2] = tm;
                samples[3] = (tm + t1) >> 1;
                samples[4] = t1;
                best = 0;
                best_len = 0;
                for (int k = 0; k < 5; k++) begin
                    dx = point_on_curve(ax, bx, cx, samples[k]) - qx;
                    dy = point_on_curve(ay, by, cy, samples[k]) - qy;
                    sq_len = dx * dx + dy * dy;
                    // Strict compare keeps the earlier sample on a tie.
                    if (k == 0 || sq_len < best_len) begin
                        best = k;
                        best_len = sq_len;
                    end
                end
                t0 = samples[(best > 0) ? best - 1 : 0];
                t1 = samples[(best < 4) ? best + 1 : 4];
                tm = (t0 + t1) >> 1;
            end
            r.near_x = t_coord'(point_on_curve(ax, bx, cx, tm));
            r.near_y = t_coord'(point_on_curve(ay, by, cy, tm));
            r.near_t = t_param'(tm);
            return r;
        endfunction

        function void note_query(t_in_word q);
            pending.push_back(search_nearest(q));
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: x=%0d y=%0d t=%0d",
                             got.near_x, got.near_y, got.near_t);
                return;
            end
            want = pending.pop_front();
            if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
                got.near_t !== want.near_t) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: want x=%0d y=%0d t=%0d, got x=%0d y=%0d t=%0d",
                             want.near_x, want.near_y, want.near_t,
                             got.near_x, got.near_y, got.near_t);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_word                i_in_word;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_word               o_out_word;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [COORD_BITS-1:0]   i_cfg_data;

    closest_point_board board = new();
    t_idle_mode         idle_mode = IDLE_SENDER_LIGHT;

    quad_bezier_closest_point_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Generous upper bound: far above the slowest legal run with both idle
    // patterns applied to every word.
    initial begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: checks each accepted result word, then picks the stall for
    // the next cycle. Once, after enough results, it holds off for a long
    // stretch so that the row fills up and pushes back on the sender.
    int  results_seen = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_word);
            results_seen++;
        end
        if (!hold_done && results_seen >= HOLD_AT_COUNT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idle_mode == IDLE_SENDER_LIGHT) begin
            i_out_stall <= ($urandom_range(99) < 80);
        end else if (idle_mode == IDLE_RECEIVER_LIGHT) begin
            i_out_stall <= ($urandom_range(99) < 23);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Writes one register; the caller lowers the valid after its last write.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, t_coord data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic load_curve(t_coord sx, t_coord sy, t_coord hx, t_coord hy,
                              t_coord fx, t_coord fy);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_HANDLE_X, hx);
        write_reg(REG_HANDLE_Y, hy);
        write_reg(REG_FINISH_X, fx);
        write_reg(REG_FINISH_Y, fy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one query word; the sender may first go idle for a random gap.
    // The valid stays high after acceptance so that back-to-back words flow.
    task automatic send_query(t_in_word q);
        int gap;
        if (idle_mode == IDLE_SENDER_LIGHT) begin
            gap = ($urandom_range(99) < 23) ? $urandom_range(4, 1) : 0;
        end else if (idle_mode == IDLE_RECEIVER_LIGHT) begin
            gap = ($urandom_range(99) < 80) ? $urandom_range(4, 1) : 0;
        end else begin
            gap = 0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= q;
        do @(posedge i_clk); while (o_in_stall);
        board.note_query(q);
    endtask

    function automatic t_coord random_coord();
        return t_coord'($urandom);
    endfunction

    // Half the queries land close to a control point so that the search has to
    // pick between near samples; the rest span the whole coordinate range.
    function automatic t_in_word random_query();
        t_in_word q;
        int       pick;
        if ($urandom_range(1) == 0) begin
            q.query_x = random_coord();
            q.query_y = random_coord();
        end else begin
            pick = 2 * $urandom_range(2);
            q.query_x = board.ctrl[pick] + t_coord'($signed($urandom_range(8191)) - 4096);
            q.query_y = board.ctrl[pick + 1] + t_coord'($signed($urandom_range(8191)) - 4096);
        end
        return q;
    endfunction

    // Stops offering, waits until every expected word is back and lets the
    // row run empty before the control points may change.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) send_query(random_query());
    endtask

    t_in_word q;

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Curve collapsed to the origin after reset: query at the corners
        // of the coordinate range and at the origin itself.
        idle_mode = IDLE_SENDER_LIGHT;
        q = '{query_x: t_coord'(COORD_MAX), query_y: t_coord'(COORD_MAX)}; send_query(q);
        q = '{query_x: t_coord'(COORD_MIN), query_y: t_coord'(COORD_MIN)}; send_query(q);
        q = '{query_x: t_coord'(COORD_MAX), query_y: t_coord'(COORD_MIN)}; send_query(q);
        q = '{query_x: t_coord'(COORD_MIN), query_y: t_coord'(COORD_MAX)}; send_query(q);
        q = '{query_x: '0, query_y: '0}; send_query(q);
        q = '{query_x: t_coord'(-1), query_y: t_coord'(1)}; send_query(q);
        drain();

        // Symmetric arch: queries on the axis of symmetry give equal
        // distances on both sides, so the earlier sample must win. Queries
        // beyond the ends push the winner to the first or the last sample.
        load_curve(-24'sd65536, 24'sd0, 24'sd0, 24'sd131072, 24'sd65536, 24'sd0);
        q = '{query_x: '0, query_y: t_coord'(-24'sd500000)}; send_query(q);
        q = '{query_x: '0, query_y: t_coord'(24'sd70000)};   send_query(q);
        q = '{query_x: '0, query_y: '0};                     send_query(q);
        q = '{query_x: t_coord'(-24'sd300000), query_y: '0}; send_query(q);
        q = '{query_x: t_coord'(24'sd300000), query_y: '0};  send_query(q);
        q = '{query_x: t_coord'(-24'sd65536), query_y: '0};  send_query(q);
        q = '{query_x: t_coord'(24'sd65536), query_y: '0};   send_query(q);
        q = '{query_x: t_coord'(COORD_MIN), query_y: t_coord'(COORD_MAX)}; send_query(q);
        send_random(ITEMS_PER_SET);
        drain();

        // Control points at the extremes of the range: intermediate points
        // can round past the range and must saturate.
        idle_mode = IDLE_RECEIVER_LIGHT;
        load_curve(t_coord'(COORD_MAX), t_coord'(COORD_MIN), t_coord'(COORD_MIN),
                   t_coord'(COORD_MAX), t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        q = '{query_x: t_coord'(COORD_MIN), query_y: t_coord'(COORD_MAX)}; send_query(q);
        q = '{query_x: t_coord'(COORD_MAX), query_y: t_coord'(COORD_MIN)}; send_query(q);
        send_random(ITEMS_PER_SET);
        drain();

        load_curve(random_coord(), random_coord(), random_coord(),
                   random_coord(), random_coord(), random_coord());
        send_random(ITEMS_PER_SET);
        drain();

        // Small curve near the origin, with fine detail in the low bits.
        idle_mode = IDLE_NONE;
        load_curve(t_coord'($urandom_range(4095)), t_coord'($urandom_range(4095)),
                   t_coord'(-$urandom_range(4095)), t_coord'($urandom_range(4095)),
                   t_coord'($urandom_range(4095)), t_coord'(-$urandom_range(4095)));
        send_random(ITEMS_PER_SET);
        drain();

        // Writes to the unused register indexes must leave the curve alone.
        load_curve(random_coord(), random_coord(), random_coord(),
                   random_coord(), random_coord(), random_coord());
        write_reg(CFG_IDX_BITS'(REG_FINISH_Y + 1), random_coord());
        write_reg(CFG_IDX_BITS'(REG_FINISH_Y + 2), random_coord());
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_random(ITEMS_PER_SET);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ quad_bezier_closest_point_top.f @@
rtl/qbcp_pkg.sv
rtl/qbcp_cell.sv
rtl/qbcp_finish.sv
rtl/quad_bezier_closest_point_top.sv
verif/quad_bezier_closest_point_top_tb.sv
